// ----- rtl/conv_5x5_multichannel_relu_defines.svh -----
// Assertion macros shared by the convolution block.
// No dependencies; included by the back part, the only module that carries assertions.
`ifndef CONV_5X5_MULTICHANNEL_RELU_DEFINES_SVH
`define CONV_5X5_MULTICHANNEL_RELU_DEFINES_SVH

`define C5_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define C5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/c5mcr_pkg.sv -----
// Shared constants and types of the convolution block.
// No dependencies; imported by the front, the back and the top level.
package c5mcr_pkg;

    localparam int IN_CH    = 6;
    localparam int OUT_CH   = 16;
    localparam int IMG      = 14;
    localparam int KSZ      = 5;
    localparam int WIN_TAPS = KSZ * KSZ;
    localparam int OC_TAPS  = IN_CH * WIN_TAPS;
    localparam int W_DEPTH  = OUT_CH * OC_TAPS;
    localparam int L_DEPTH  = KSZ * IMG * IN_CH;

    localparam int W_AW  = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int L_AW  = (L_DEPTH > 1) ? $clog2(L_DEPTH) : 1;
    localparam int CH_W  = (IN_CH > 1) ? $clog2(IN_CH) : 1;
    localparam int OC_W  = (OUT_CH > 1) ? $clog2(OUT_CH) : 1;
    localparam int POS_W = (IMG > 1) ? $clog2(IMG) : 1;
    localparam int K_W   = (KSZ > 1) ? $clog2(KSZ) : 1;
    localparam int ACC_W = 48;
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_BIAS   = 2'd1,
        KIND_ELEM   = 2'd2
    } t_kind;

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_ELEM   = 2'd2;

    typedef struct packed {
        t_kind              kind;
        logic [W_AW-1:0]    widx;
        logic [OC_W-1:0]    bidx;
        logic signed [15:0] value;
        logic [L_AW-1:0]    laddr;
        logic               win;
        logic [POS_W-1:0]   top;
        logic [POS_W-1:0]   left;
        logic [K_W-1:0]     top_slot;
    } t_item;

endpackage

// ----- rtl/c5mcr_front.sv -----
// Front part: accepts items, classifies them, tracks the raster position and queues
// the valid ones for the back part. Depends on c5mcr_pkg.
module c5mcr_front
    import c5mcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_index,
    input  logic signed [15:0] i_value,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);

    t_item r_q [Q_DEPTH];
    logic [$clog2(Q_DEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(Q_DEPTH+1)-1:0] r_cnt;
    logic [CH_W-1:0]  r_chan;
    logic [POS_W-1:0] r_col, r_row;
    logic [K_W-1:0]   r_slot;

    logic  acc, keep, is_elem, do_pop;
    t_item item;

    assign full      = (r_cnt == ($clog2(Q_DEPTH+1))'(Q_DEPTH));
    assign acc       = push && !full;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rp];
    assign do_pop    = i_q_pop && o_q_valid;
    assign is_elem   = (i_cmd == CMD_ELEM);

    always_comb begin
        item          = '0;
        item.widx     = W_AW'(i_index);
        item.bidx     = OC_W'(i_index);
        item.value    = i_value;
        item.laddr    = L_AW'((int'(r_slot) * IMG + int'(r_col)) * IN_CH + int'(r_chan));
        item.win      = (int'(r_chan) == IN_CH - 1) && (int'(r_row) >= KSZ - 1)
                        && (int'(r_col) >= KSZ - 1);
        item.top      = POS_W'(int'(r_row) - (KSZ - 1));
        item.left     = POS_W'(int'(r_col) - (KSZ - 1));
        item.top_slot = (int'(r_slot) == KSZ - 1) ? '0 : r_slot + 1'b1;
        keep          = 1'b0;
        case (i_cmd)
            CMD_WEIGHT: begin
                item.kind = KIND_WEIGHT;
                keep      = (int'(i_index) < W_DEPTH);
            end
            CMD_BIAS: begin
                item.kind = KIND_BIAS;
                keep      = (int'(i_index) < OUT_CH);
            end
            CMD_ELEM: begin
                item.kind = KIND_ELEM;
                keep      = 1'b1;
            end
            default: begin
                item.kind = KIND_ELEM;
                keep      = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc && keep) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_chan <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else begin
            if (acc && keep) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (($clog2(Q_DEPTH+1))'(acc && keep))
                     - (($clog2(Q_DEPTH+1))'(do_pop));
            if (acc && is_elem) begin
                if (int'(r_chan) == IN_CH - 1) begin
                    r_chan <= '0;
                    if (int'(r_col) == IMG - 1) begin
                        r_col <= '0;
                        if (int'(r_row) == IMG - 1) begin
                            r_row  <= '0;
                            r_slot <= '0;
                        end else begin
                            r_row  <= r_row + 1'b1;
                            r_slot <= (int'(r_slot) == KSZ - 1) ? '0 : r_slot + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end else begin
                    r_chan <= r_chan + 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/c5mcr_back.sv -----
// Back part: stores weights, biases and lines, runs the multiply-accumulate
// sequence per output channel and holds the result register. Depends on c5mcr_pkg.
`include "conv_5x5_multichannel_relu_defines.svh"
module c5mcr_back
    import c5mcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_out_channel,
    output logic [3:0]  o_out_row,
    output logic [3:0]  o_out_col,
    output logic [14:0] o_result,
    output logic        o_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_WAIT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    logic signed [15:0] r_wmem [W_DEPTH];
    logic signed [15:0] r_lmem [L_DEPTH];
    logic signed [15:0] r_bias [OUT_CH];
    logic signed [15:0] r_wdata, r_ldata;
    logic signed [31:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic r_p1_v, r_p2_v;

    logic [OC_W-1:0]  r_oc;
    logic [CH_W-1:0]  r_ic;
    logic [K_W-1:0]   r_ky, r_kx, r_slot, r_top_slot;
    logic [POS_W-1:0] r_top, r_left;
    logic [W_AW-1:0]  r_waddr;

    logic r_ov;
    logic [3:0]  r_o_ch, r_o_row, r_o_col;
    logic [14:0] r_o_res;
    logic        r_o_last;

    logic idle_take, issue, out_load;
    logic [L_AW-1:0] raddr;
    logic signed [ACC_W-1:0] sum, shifted;
    logic [14:0] res;

    assign idle_take = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop   = idle_take;
    assign issue     = (r_state == S_MAC);
    assign out_load  = (r_state == S_OUT) && (!r_ov || pop);
    assign raddr     = L_AW'((int'(r_slot) * IMG + int'(r_left) + int'(r_kx)) * IN_CH
                       + int'(r_ic));

    always_comb begin
        sum     = r_acc + (ACC_W'(r_bias[r_oc]) <<< 8);
        shifted = sum >>> 8;
        if (sum < ACC_W'(256)) begin
            res = '0;
        end else if (shifted > ACC_W'(32767)) begin
            res = 15'h7fff;
        end else begin
            res = shifted[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (idle_take && i_q_item.kind == KIND_WEIGHT) begin
            r_wmem[i_q_item.widx] <= i_q_item.value;
        end
        r_wdata <= r_wmem[r_waddr];
    end

    always_ff @(posedge i_clk) begin
        if (idle_take && i_q_item.kind == KIND_ELEM) begin
            r_lmem[i_q_item.laddr] <= i_q_item.value;
        end
        r_ldata <= r_lmem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (idle_take && i_q_item.kind == KIND_BIAS) begin
            r_bias[i_q_item.bidx] <= i_q_item.value;
        end
        r_prod <= r_wdata * r_ldata;
        if (out_load) begin
            r_o_ch   <= 4'(r_oc);
            r_o_row  <= 4'(r_top);
            r_o_col  <= 4'(r_left);
            r_o_res  <= res;
            r_o_last <= (int'(r_oc) == OUT_CH - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_p1_v     <= 1'b0;
            r_p2_v     <= 1'b0;
            r_ov       <= 1'b0;
            r_acc      <= '0;
            r_oc       <= '0;
            r_ic       <= '0;
            r_ky       <= '0;
            r_kx       <= '0;
            r_slot     <= '0;
            r_top_slot <= '0;
            r_top      <= '0;
            r_left     <= '0;
            r_waddr    <= '0;
        end else begin
            r_p1_v <= issue;
            r_p2_v <= r_p1_v;
            if (r_p2_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (pop) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (idle_take && i_q_item.kind == KIND_ELEM && i_q_item.win) begin
                        r_top      <= i_q_item.top;
                        r_left     <= i_q_item.left;
                        r_top_slot <= i_q_item.top_slot;
                        r_slot     <= i_q_item.top_slot;
                        r_oc       <= '0;
                        r_ic       <= '0;
                        r_ky       <= '0;
                        r_kx       <= '0;
                        r_waddr    <= '0;
                        r_acc      <= '0;
                        r_state    <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_waddr <= r_waddr + 1'b1;
                    if (int'(r_kx) == KSZ - 1) begin
                        r_kx <= '0;
                        if (int'(r_ky) == KSZ - 1) begin
                            r_ky   <= '0;
                            r_slot <= r_top_slot;
                            if (int'(r_ic) == IN_CH - 1) begin
                                r_ic    <= '0;
                                r_state <= S_WAIT;
                            end else begin
                                r_ic <= r_ic + 1'b1;
                            end
                        end else begin
                            r_ky   <= r_ky + 1'b1;
                            r_slot <= (int'(r_slot) == KSZ - 1) ? '0 : r_slot + 1'b1;
                        end
                    end else begin
                        r_kx <= r_kx + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (!r_p1_v && !r_p2_v) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        if (int'(r_oc) == OUT_CH - 1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_oc    <= r_oc + 1'b1;
                            r_acc   <= '0;
                            r_state <= S_MAC;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign empty         = !r_ov;
    assign o_out_channel = r_o_ch;
    assign o_out_row     = r_o_row;
    assign o_out_col     = r_o_col;
    assign o_result      = r_o_res;
    assign o_last        = r_o_last;

    `C5_ASSERT_NOW(a_drained_at_out, r_state == S_OUT, !r_p1_v && !r_p2_v, "pipeline busy at output")
    `C5_ASSERT_NOW(a_idle_no_issue, r_state == S_IDLE, !r_p1_v && !r_p2_v, "pipeline busy when idle")
    `C5_ASSERT_NEXT(a_last_to_idle, out_load && int'(r_oc) == OUT_CH - 1, r_state == S_IDLE, "no return to idle after last channel")
    `C5_ASSERT_NEXT(a_load_valid, out_load, !empty, "loaded result not shown")

endmodule

// ----- rtl/conv_5x5_multichannel_relu.sv -----
// 5x5 convolution with bias and ReLU over a multichannel Q8.8 feature map.
// Weight, bias and element items without a full window are stored while the back part stays idle.
// A window position runs, for each of the 16 output channels in turn, 150 MAC steps on one
// multiplier, then waits for the read, product and accumulate registers to drain and
// loads the result into the output register.
// Synchronous active-low reset clears counters and queues; stores are undefined until written.
module conv_5x5_multichannel_relu
    import c5mcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_index,
    input  logic signed [15:0] i_value,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_out_channel,
    output logic [3:0]  o_out_row,
    output logic [3:0]  o_out_col,
    output logic [14:0] o_result,
    output logic        o_last
);

    logic  q_valid, q_pop;
    t_item q_item;

    c5mcr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_cmd     (i_cmd),
        .i_index   (i_index),
        .i_value   (i_value),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    c5mcr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_out_channel (o_out_channel),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_result      (o_result),
        .o_last        (o_last)
    );

endmodule

// ----- sim/tb_conv_5x5_multichannel_relu.sv -----
// Self-checking testbench for the 5x5 multichannel convolution with bias and ReLU.
// It loads every weight and bias, streams more than one image with random idling and checks
// each result against its own model of the layer; it depends on c5mcr_pkg and the top level.
`timescale 1ns / 100ps

module tb_conv_5x5_multichannel_relu;
    import c5mcr_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int IMG_ELEMS = IMG * IMG * IN_CH;

    typedef struct {
        bit [3:0]  channel;
        bit [3:0]  row;
        bit [3:0]  col;
        bit [14:0] value;
        bit        last;
    } t_conv_result;

    class t_conv_scoreboard;
        shortint      weights[W_DEPTH];
        shortint      biases[OUT_CH];
        shortint      lines[L_DEPTH];
        int           chan;
        int           col;
        int           row;
        t_conv_result pending[$];
        int           errors;
        int           checked;

        function void report(string what, int got, int want);
            $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, checked);
            errors++;
        endfunction

        function bit [14:0] window_sum(int oc, int top, int left);
            longint acc;
            acc = 0;
            for (int ic = 0; ic < IN_CH; ic++) begin
                for (int ky = 0; ky < KSZ; ky++) begin
                    for (int kx = 0; kx < KSZ; kx++) begin
                        acc += longint'(weights[oc * OC_TAPS + ic * WIN_TAPS + ky * KSZ + kx])
                             * longint'(lines[(((top + ky) % KSZ) * IMG + left + kx) * IN_CH + ic]);
                    end
                end
            end
            acc += longint'(biases[oc]) * 256;
            if (acc < 256) begin
                return 0;
            end
            acc = acc >>> 8;
            return (acc > 32767) ? 15'h7fff : acc[14:0];
        endfunction

        function void note_item(logic [1:0] cmd, logic [11:0] idx, logic [15:0] val);
            t_conv_result r;
            if (cmd == CMD_WEIGHT) begin
                if (idx < W_DEPTH) begin
                    weights[idx] = val;
                end
            end else if (cmd == CMD_BIAS) begin
                if (idx < OUT_CH) begin
                    biases[idx] = val;
                end
            end else if (cmd == CMD_ELEM) begin
                lines[((row % KSZ) * IMG + col) * IN_CH + chan] = val;
                if (chan == IN_CH - 1 && row >= KSZ - 1 && col >= KSZ - 1) begin
                    for (int oc = 0; oc < OUT_CH; oc++) begin
                        r.channel = 4'(oc);
                        r.row = 4'(row - (KSZ - 1));
                        r.col = 4'(col - (KSZ - 1));
                        r.value = window_sum(oc, row - (KSZ - 1), col - (KSZ - 1));
                        r.last = (oc == OUT_CH - 1);
                        pending.push_back(r);
                    end
                end
                chan++;
                if (chan >= IN_CH) begin
                    chan = 0;
                    col++;
                    if (col >= IMG) begin
                        col = 0;
                        row++;
                        if (row >= IMG) begin
                            row = 0;
                        end
                    end
                end
            end
        endfunction

        function void check_result(t_conv_result got);
            t_conv_result want;
            checked++;
            if (pending.size() == 0) begin
                report("results waiting", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (got.channel != want.channel) report("out_channel", int'(got.channel),
                                                    int'(want.channel));
            if (got.row != want.row) report("out_row", int'(got.row), int'(want.row));
            if (got.col != want.col) report("out_col", int'(got.col), int'(want.col));
            if (got.value != want.value) report("result", int'(got.value), int'(want.value));
            if (got.last != want.last) report("last", int'(got.last), int'(want.last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_cmd;
    logic [11:0] i_index;
    logic signed [15:0] i_value;
    logic        empty;
    logic        pop;
    logic [3:0]  o_out_channel;
    logic [3:0]  o_out_row;
    logic [3:0]  o_out_col;
    logic [14:0] o_result;
    logic        o_last;

    t_conv_scoreboard model = new();
    int  cycles;
    int  items_sent;
    int  elems_sent;
    bit  want_holdoff;

    conv_5x5_multichannel_relu dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_cmd(i_cmd), .i_index(i_index), .i_value(i_value),
        .empty(empty), .pop(pop),
        .o_out_channel(o_out_channel), .o_out_row(o_out_row), .o_out_col(o_out_col),
        .o_result(o_result), .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [15:0] draw_small();
        return 16'($signed($urandom_range(0, 511)) - 256);
    endfunction

    function automatic logic [15:0] draw_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2, 3: return 16'($urandom);
            default: return draw_small();
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(logic [1:0] cmd, logic [11:0] idx, logic [15:0] val);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_cmd <= cmd;
        i_index <= idx;
        i_value <= val;
        do @(posedge i_clk); while (full);
        model.note_item(cmd, idx, val);
        items_sent++;
        if (cmd == CMD_ELEM) begin
            elems_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (model.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin : receiver
        int wait_cnt;
        int hold;
        t_conv_result got;
        wait_cnt = 0;
        hold = 0;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got.channel = o_out_channel;
                got.row = o_out_row;
                got.col = o_out_col;
                got.value = o_result;
                got.last = o_last;
                model.check_result(got);
                wait_cnt = draw_gap();
            end
            @(negedge i_clk);
            if (want_holdoff) begin
                want_holdoff = 1'b0;
                hold = 8000;
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else if (wait_cnt > 0) begin
                wait_cnt--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int pick;
        cycles = 0;
        want_holdoff = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_cmd = CMD_NONE;
        i_index = '0;
        i_value = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < W_DEPTH; i++) begin
            send_item(CMD_WEIGHT, 12'(i), ($urandom_range(0, 99) == 0) ? draw_value() : draw_small());
        end
        for (int i = 0; i < OUT_CH; i++) begin
            send_item(CMD_BIAS, 12'(i), draw_value());
        end

        send_item(CMD_NONE, 12'hfff, 16'hffff);
        send_item(CMD_NONE, 12'h000, 16'h0000);
        send_item(CMD_WEIGHT, 12'(W_DEPTH), 16'h7fff);
        send_item(CMD_WEIGHT, 12'hfff, 16'h8000);
        send_item(CMD_BIAS, 12'(OUT_CH), 16'h7fff);
        send_item(CMD_BIAS, 12'hfff, 16'h8000);
        send_item(CMD_BIAS, 12'd0, 16'h8000);
        send_item(CMD_BIAS, 12'(OUT_CH - 1), 16'h7fff);
        send_item(CMD_WEIGHT, 12'(W_DEPTH - 1), 16'h7fff);
        send_item(CMD_WEIGHT, 12'd0, 16'h8000);
        drain_results();

        // One image and 420 more elements so that the wrap to a new image is crossed.
        while (elems_sent < IMG_ELEMS + 420) begin
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
                send_item(CMD_ELEM, 12'($urandom), draw_value());
                if (elems_sent == 400) begin
                    want_holdoff = 1'b1;
                end
                if (elems_sent == IMG_ELEMS / 2) begin
                    drain_results();
                end
            end else if (pick < 94) begin
                send_item(CMD_WEIGHT, 12'($urandom_range(0, 4095)), draw_value());
            end else if (pick < 98) begin
                send_item(CMD_BIAS, 12'($urandom_range(0, 31)), draw_value());
            end else begin
                send_item(CMD_NONE, 12'($urandom), 16'($urandom));
            end
        end

        drain_results();
        repeat (200) @(negedge i_clk);
        $display("Sent %0d items (%0d elements, more than one image) and checked %0d results.",
                 items_sent, elems_sent, model.checked);
        if (model.errors == 0 && model.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ----- conv_5x5_multichannel_relu.f -----
+incdir+rtl
rtl/c5mcr_pkg.sv
rtl/c5mcr_front.sv
rtl/c5mcr_back.sv
rtl/conv_5x5_multichannel_relu.sv
sim/tb_conv_5x5_multichannel_relu.sv
